// ----- src/stcp_pkg.sv -----
// shared types and constants for the serial tuning command parser
package stcp_pkg;

  // number of fraction digits kept by the parser
  localparam int FRAC_DIGITS = 4;

  // ascii codes seen by the parser
  localparam logic [7:0] CH_NONE  = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_S     = 8'h53;

  // configuration register indexes
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_SP_LOW  = 2'd1;
  localparam logic [1:0] REG_SP_HIGH = 2'd2;

  // operating modes
  localparam logic [1:0] MODE_GAINS    = 2'd0;
  localparam logic [1:0] MODE_SETPOINT = 2'd1;
  localparam logic [1:0] MODE_SUCTION  = 2'd2;

  // result destinations
  typedef enum logic [2:0] {
    TGT_KP       = 3'd0,
    TGT_KI       = 3'd1,
    TGT_KD       = 3'd2,
    TGT_SPEED    = 3'd3,
    TGT_SETPOINT = 3'd4,
    TGT_SUCTION  = 3'd5
  } target_t;

  // one executed command with its parsed number
  typedef struct packed {
    target_t     target;
    logic [15:0] int_part;
    logic [13:0] frac_digits;
    logic [2:0]  frac_count;
    logic        negative;
  } cmd_t;

endpackage

// ----- src/stcp_parser.sv -----
// byte parser: number accumulation, idle timeout and command dispatch
module stcp_parser #(
  parameter int IDLE_LIMIT = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             func,
  input  logic [7:0]       rx_byte,
  input  logic [1:0]       mode,
  output logic             emit,
  output stcp_pkg::cmd_t   cmd
);

  localparam int IDLE_W = $clog2(IDLE_LIMIT + 2);
  localparam logic [IDLE_W-1:0] IDLE_MAX = IDLE_W'(IDLE_LIMIT);

  logic [7:0]        pending_letter, pending_letter_next;
  logic [15:0]       int_part, int_part_next;
  logic [13:0]       frac_digits, frac_digits_next;
  logic [2:0]        frac_count, frac_count_next;
  logic              negative, negative_next;
  logic              point_seen, point_seen_next;
  logic              stopped, stopped_next;
  logic              any_chars, any_chars_next;
  logic [IDLE_W-1:0] idle_ticks, idle_ticks_next;

  logic              is_digit, is_num, fire, clear_num, known;
  logic [3:0]        digit;
  logic [19:0]       int_sum;
  stcp_pkg::target_t target;

  assign is_digit = (rx_byte >= stcp_pkg::CH_ZERO) && (rx_byte <= stcp_pkg::CH_NINE);
  assign is_num   = is_digit || (rx_byte == stcp_pkg::CH_POINT) ||
                    (rx_byte == stcp_pkg::CH_MINUS);
  assign digit    = rx_byte[3:0];
  assign int_sum  = (20'(int_part) << 3) + (20'(int_part) << 1) + 20'(digit);

  // next parser state for the item on the input
  always_comb begin
    pending_letter_next = pending_letter;
    int_part_next       = int_part;
    frac_digits_next    = frac_digits;
    frac_count_next     = frac_count;
    negative_next       = negative;
    point_seen_next     = point_seen;
    stopped_next        = stopped;
    any_chars_next      = any_chars;
    idle_ticks_next     = idle_ticks;
    fire                = 1'b0;
    clear_num           = 1'b0;
    if (func) begin
      if (idle_ticks <= IDLE_MAX) begin
        idle_ticks_next = idle_ticks + IDLE_W'(1);
      end
      if ((idle_ticks >= IDLE_MAX) && (pending_letter != stcp_pkg::CH_NONE)) begin
        fire                = 1'b1;
        clear_num           = 1'b1;
        pending_letter_next = stcp_pkg::CH_NONE;
      end
    end else begin
      idle_ticks_next = '0;
      if (is_num) begin
        any_chars_next = 1'b1;
        if (!stopped) begin
          if (rx_byte == stcp_pkg::CH_MINUS) begin
            if (!any_chars) negative_next = 1'b1;
            else stopped_next = 1'b1;
          end else if (rx_byte == stcp_pkg::CH_POINT) begin
            if (point_seen) stopped_next = 1'b1;
            else point_seen_next = 1'b1;
          end else if (!point_seen) begin
            int_part_next = (int_sum > 20'd65535) ? 16'hFFFF : int_sum[15:0];
          end else if (frac_count < 3'(stcp_pkg::FRAC_DIGITS)) begin
            frac_digits_next = (frac_digits << 3) + (frac_digits << 1) + 14'(digit);
            frac_count_next  = frac_count + 3'd1;
          end
        end
      end else begin
        fire                = (pending_letter != stcp_pkg::CH_NONE);
        clear_num           = 1'b1;
        pending_letter_next = rx_byte;
      end
    end
    if (clear_num) begin
      int_part_next    = '0;
      frac_digits_next = '0;
      frac_count_next  = '0;
      negative_next    = 1'b0;
      point_seen_next  = 1'b0;
      stopped_next     = 1'b0;
      any_chars_next   = 1'b0;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_letter <= stcp_pkg::CH_NONE;
      int_part       <= '0;
      frac_digits    <= '0;
      frac_count     <= '0;
      negative       <= 1'b0;
      point_seen     <= 1'b0;
      stopped        <= 1'b0;
      any_chars      <= 1'b0;
      idle_ticks     <= '0;
    end else if (accept) begin
      pending_letter <= pending_letter_next;
      int_part       <= int_part_next;
      frac_digits    <= frac_digits_next;
      frac_count     <= frac_count_next;
      negative       <= negative_next;
      point_seen     <= point_seen_next;
      stopped        <= stopped_next;
      any_chars      <= any_chars_next;
      idle_ticks     <= idle_ticks_next;
    end
  end

  // letter decode and mode gating
  always_comb begin
    target = stcp_pkg::TGT_KP;
    known  = 1'b1;
    case (pending_letter)
      stcp_pkg::CH_P: target = stcp_pkg::TGT_KP;
      stcp_pkg::CH_I: target = stcp_pkg::TGT_KI;
      stcp_pkg::CH_D: target = stcp_pkg::TGT_KD;
      stcp_pkg::CH_V: target = stcp_pkg::TGT_SPEED;
      stcp_pkg::CH_X: begin
        target = stcp_pkg::TGT_SETPOINT;
        known  = (mode >= stcp_pkg::MODE_SETPOINT);
      end
      stcp_pkg::CH_S: begin
        target = stcp_pkg::TGT_SUCTION;
        known  = (mode >= stcp_pkg::MODE_SUCTION);
      end
      default: known = 1'b0;
    endcase
  end

  // command snapshot taken before the number is cleared
  always_comb begin
    cmd.target      = target;
    cmd.int_part    = int_part;
    cmd.frac_digits = frac_digits;
    cmd.frac_count  = frac_count;
    cmd.negative    = negative;
  end

  assign emit = accept && fire && known;

endmodule

// ----- src/stcp_eval.sv -----
// value pipeline: q16.16 conversion, integer truncation and setpoint mapping
module stcp_eval (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  stcp_pkg::cmd_t      cmd,
  input  logic signed [15:0]  sp_low,
  input  logic signed [15:0]  sp_high,
  output logic                out_valid,
  input  logic                out_ready,
  output stcp_pkg::target_t   out_target,
  output logic [31:0]         out_value
);

  // reciprocal of 1000 for the setpoint division, exact for 27-bit dividends
  localparam logic [27:0] X_RECIP = 28'd137438954;
  localparam int          X_SHIFT = 37;

  // reciprocal of 2*5^k for the rounded fraction, k fraction digits
  function automatic logic [27:0] frac_recip(input logic [2:0] k);
    logic [27:0] r;
    case (k)
      3'd0:    r = 28'd134217728;
      3'd1:    r = 28'd214748365;
      3'd2:    r = 28'd171798692;
      3'd3:    r = 28'd137438954;
      default: r = 28'd219902326;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] frac_shift(input logic [2:0] k);
    logic [5:0] s;
    case (k)
      3'd0:    s = 6'd28;
      3'd1:    s = 6'd31;
      3'd2:    s = 6'd33;
      3'd3:    s = 6'd35;
      default: s = 6'd38;
    endcase
    return s;
  endfunction

  function automatic logic [10:0] five_pow_full(input logic [2:0] k);
    logic [10:0] p;
    case (k)
      3'd0:    p = 11'd1;
      3'd1:    p = 11'd5;
      3'd2:    p = 11'd25;
      3'd3:    p = 11'd125;
      default: p = 11'd625;
    endcase
    return p;
  endfunction

  // clamp a 20-bit signed value to 16 bits, sign extended to the result width
  function automatic logic [31:0] sat16(input logic signed [19:0] v);
    logic [31:0] r;
    if (v > 20'sd32767) r = 32'h0000_7FFF;
    else if (v < -20'sd32768) r = 32'hFFFF_8000;
    else r = 32'(v);
    return r;
  endfunction

  // stage valid bits and ready chain
  logic v1, v2, v3, vo;
  logic rdy1, rdy2, rdy3, rdyo;

  assign rdyo      = !vo || out_ready;
  assign rdy3      = !v3 || rdyo;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign cmd_ready = rdy1;

  // stage payloads
  stcp_pkg::cmd_t    c1;
  stcp_pkg::target_t t2, t3;
  logic [15:0]       int2, int3;
  logic              neg2, neg3;
  logic [26:0]       fnum2;
  logic [2:0]        fcnt2, fcnt3;
  logic signed [34:0] xprod2;
  logic [54:0]       fprod3, xquot3;
  logic              xneg3;

  // stage 2 logic: fraction numerator and setpoint product
  logic signed [16:0] xs;
  logic signed [17:0] xoff;
  logic signed [16:0] diff;
  logic [26:0]        fnum;
  logic signed [34:0] xprod;

  assign fnum  = (27'(c1.frac_digits) << (5'd17 - 5'(c1.frac_count))) +
                 27'(five_pow_full(c1.frac_count));
  assign xs    = c1.negative ? -$signed({1'b0, c1.int_part}) : $signed({1'b0, c1.int_part});
  assign xoff  = 18'(xs) + 18'sd500;
  assign diff  = 17'(sp_high) - 17'(sp_low);
  assign xprod = 35'(xoff) * 35'(diff);

  // stage 3 logic: reciprocal multiplies
  logic [34:0] xabs;
  logic [26:0] xclamp;
  logic [54:0] fprod, xquot;

  assign xabs   = xprod2[34] ? 35'(-xprod2) : 35'(xprod2);
  assign xclamp = (xabs[34:27] != 8'd0) ? 27'h7FF_FFFF : xabs[26:0];
  assign fprod  = 55'(fnum2) * 55'(frac_recip(fcnt2));
  assign xquot  = 55'(xclamp) * 55'(X_RECIP);

  // output logic: assemble and saturate
  logic [16:0]        fq;
  logic [32:0]        mag;
  logic [31:0]        qval;
  logic [17:0]        xq;
  logic signed [18:0] xr;
  logic signed [19:0] xsum;
  logic signed [16:0] ti;
  logic [31:0]        value_next;

  assign fq   = 17'(fprod3 >> frac_shift(fcnt3));
  assign mag  = 33'({int3, 16'h0000}) + 33'(fq);
  assign xq   = 18'(xquot3 >> X_SHIFT);
  assign xr   = xneg3 ? -$signed({1'b0, xq}) : $signed({1'b0, xq});
  assign xsum = 20'(xr) + 20'(sp_low);
  assign ti   = neg3 ? -$signed({1'b0, int3}) : $signed({1'b0, int3});

  always_comb begin
    if (neg3) qval = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-mag);
    else      qval = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  end

  always_comb begin
    case (t3)
      stcp_pkg::TGT_KP, stcp_pkg::TGT_KI, stcp_pkg::TGT_KD: value_next = qval;
      stcp_pkg::TGT_SETPOINT: value_next = sat16(xsum);
      default: value_next = sat16(20'(ti));
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy1) v1 <= cmd_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdyo) vo <= v3;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1 && cmd_valid) c1 <= cmd;
    if (rdy2 && v1) begin
      t2     <= c1.target;
      int2   <= c1.int_part;
      neg2   <= c1.negative;
      fnum2  <= fnum;
      fcnt2  <= c1.frac_count;
      xprod2 <= xprod;
    end
    if (rdy3 && v2) begin
      t3     <= t2;
      int3   <= int2;
      neg3   <= neg2;
      fcnt3  <= fcnt2;
      fprod3 <= fprod;
      xquot3 <= xquot;
      xneg3  <= xprod2[34];
    end
    if (rdyo && v3) begin
      out_target <= t3;
      out_value  <= value_next;
    end
  end

  assign out_valid = vo;

endmodule

// ----- src/serial_tuning_command_parser.sv -----
// top level of the serial tuning command parser
//
// Usage: the input stream carries one item per transfer: in_tuser high marks a
// one-millisecond tick, low a received byte in in_tdata. Digits, '.' and '-'
// build a signed decimal number; any other byte executes the pending command
// letter and becomes the next letter. More than IDLE_LIMIT ticks with no byte
// also execute the pending letter. An executed P, I, D, V, X or S (as allowed
// by mode) produces one output transfer: out_tuser gives the destination
// (0 kp, 1 ki, 2 kd, 3 speed, 4 setpoint, 5 suction), out_tdata the value.
// The configuration channel writes mode, sp_low and sp_high by index and
// is always ready; write it only while no command is in flight.
// Throughput is one input transfer per cycle while in_tready is high. A result
// passes in order through the four-register value pipeline (snapshot,
// product, reciprocal multiply, output register) before it is valid.
// Reset clears the parser, the pipeline and loads the register defaults.
// When the receiver stalls, the pipeline keeps accepting input until all of
// its stages hold results, and then in_tready drops.
module serial_tuning_command_parser #(
  parameter int IDLE_LIMIT = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value
  output logic [2:0]  out_tuser,  // target
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic signed [15:0] MIN_RESET = -16'sd100;
  localparam logic signed [15:0] MAX_RESET = 16'sd100;

  logic [1:0]         mode;
  logic signed [15:0] sp_low;
  logic signed [15:0] sp_high;

  logic               accept;
  logic               emit;
  logic               cmd_ready;
  stcp_pkg::cmd_t     cmd;
  stcp_pkg::target_t  out_target;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= stcp_pkg::MODE_SUCTION;
      sp_low  <= MIN_RESET;
      sp_high <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stcp_pkg::REG_MODE:    mode    <= cfg_data[1:0];
        stcp_pkg::REG_SP_LOW:  sp_low  <= cfg_data;
        stcp_pkg::REG_SP_HIGH: sp_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // input transfer
  assign in_tready = cmd_ready;
  assign accept    = in_tvalid && in_tready;

  stcp_parser #(
    .IDLE_LIMIT (IDLE_LIMIT)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .func    (in_tuser),
    .rx_byte (in_tdata),
    .mode    (mode),
    .emit    (emit),
    .cmd     (cmd)
  );

  stcp_eval u_eval (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (emit),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .sp_low     (sp_low),
    .sp_high    (sp_high),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_target (out_target),
    .out_value  (out_tdata)
  );

  assign out_tuser = out_target;

endmodule

// ----- src/stcp_checker.sv -----
// port-level checks for the serial tuning command parser, bound to the top level
module stcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // pipeline is empty right after reset, so input must be taken
  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_tready)
    else $error("in_tready low right after reset");

  // reset leaves no result behind
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_tvalid)
    else $error("result valid after reset");

  // only defined destinations are produced
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> (out_tuser <= 3'(stcp_pkg::TGT_SUCTION)))
    else $error("undefined target on output");

  // integer destinations carry a sign-extended 16-bit value
  a_int_range: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && (out_tuser == 3'(stcp_pkg::TGT_SPEED) ||
                   out_tuser == 3'(stcp_pkg::TGT_SETPOINT) ||
                   out_tuser == 3'(stcp_pkg::TGT_SUCTION))
    |-> (out_tdata[31:15] == 17'h00000 || out_tdata[31:15] == 17'h1FFFF))
    else $error("integer result outside 16-bit range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind serial_tuning_command_parser stcp_checker u_stcp_checker (.*);
